// ----- design/sbsp_pkg.sv -----
`default_nettype none

package sbsp_pkg;

  // Header byte that opens every status packet.
  localparam logic [7:0] HDR_BYTE = 8'hFF;
  // Smallest legal length field (error byte plus checksum byte).
  localparam logic [7:0] MIN_LEN  = 8'd2;
  // Depth of the queue between the parser and the output stage.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Result kinds as they appear on the output channel.
  typedef enum logic [2:0] {
    KIND_PARAM  = 3'd0,
    KIND_OK     = 3'd1,
    KIND_BADHDR = 3'd2,
    KIND_BADLEN = 3'd3,
    KIND_BADSUM = 3'd4
  } kind_e;

  // Parser phases, one-hot.
  typedef enum logic [6:0] {
    PH_HUNT1 = 7'b0000001,
    PH_HUNT2 = 7'b0000010,
    PH_ID    = 7'b0000100,
    PH_LEN   = 7'b0001000,
    PH_ERR   = 7'b0010000,
    PH_PARAM = 7'b0100000,
    PH_CSUM  = 7'b1000000
  } phase_e;

  // One result item as it travels through the queue.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [7:0]  packet_id;
    logic [6:0]  error_flags;
    logic        last;
  } sbsp_res_t;

  // Handshake between the queue and the output stage.
  typedef struct packed {
    logic      valid;
    sbsp_res_t res;
  } sbsp_qout_t;

endpackage

`default_nettype wire

// ----- design/sbsp_if.sv -----
`default_nettype none

// Channel that carries received bus bytes.
interface sbsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Channel that carries parser results.
interface sbsp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data;
  logic [7:0] packet_id;
  logic [6:0] error_flags;
  logic       last;

  modport source (output valid, output kind, output data, output packet_id,
                  output error_flags, output last, input ready);
  modport sink   (input valid, input kind, input data, input packet_id,
                  input error_flags, input last, output ready);
endinterface

`default_nettype wire

// ----- design/sbsp_front.sv -----
`default_nettype none

module sbsp_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  valid_i,
  input  wire  [7:0]           rx_byte_i,
  input  wire                  space_i,
  output logic                 ready_o,
  output logic                 push_o,
  output sbsp_pkg::sbsp_res_t  res_o
);
  import sbsp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  id_q, id_d;
  logic [6:0]  flags_q, flags_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  sum_q, sum_d;
  logic        accept;
  logic [7:0]  sum_add;

  assign ready_o = space_i;
  assign accept  = valid_i && space_i;
  assign sum_add = sum_q + rx_byte_i;

  // Phase step and result classification for one accepted byte.
  always_comb begin
    phase_d = phase_q;
    id_d    = id_q;
    flags_d = flags_q;
    left_d  = left_q;
    sum_d   = sum_q;
    push_o  = 1'b0;
    res_o   = '{kind: KIND_PARAM, data: 8'd0, packet_id: 8'd0,
                error_flags: 7'd0, last: 1'b0};
    if (accept) begin
      case (phase_q)
        PH_HUNT2: begin
          if (rx_byte_i == HDR_BYTE) begin
            phase_d = PH_ID;
          end else begin
            phase_d       = PH_HUNT1;
            push_o        = 1'b1;
            res_o.kind    = KIND_BADHDR;
            res_o.last    = 1'b1;
          end
        end
        PH_ID: begin
          id_d    = rx_byte_i;
          sum_d   = rx_byte_i;
          flags_d = 7'd0;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          sum_d = sum_add;
          if (rx_byte_i < MIN_LEN) begin
            phase_d         = PH_HUNT1;
            push_o          = 1'b1;
            res_o.kind      = KIND_BADLEN;
            res_o.packet_id = id_q;
            res_o.last      = 1'b1;
          end else begin
            left_d  = rx_byte_i - MIN_LEN;
            phase_d = PH_ERR;
          end
        end
        PH_ERR: begin
          flags_d = rx_byte_i[6:0];
          sum_d   = sum_add;
          phase_d = (left_q == 8'd0) ? PH_CSUM : PH_PARAM;
        end
        PH_PARAM: begin
          sum_d             = sum_add;
          left_d            = left_q - 8'd1;
          if (left_q == 8'd1) begin
            phase_d = PH_CSUM;
          end
          push_o            = 1'b1;
          res_o.kind        = KIND_PARAM;
          res_o.data        = rx_byte_i;
          res_o.packet_id   = id_q;
          res_o.error_flags = flags_q;
        end
        PH_CSUM: begin
          phase_d           = PH_HUNT1;
          push_o            = 1'b1;
          res_o.kind        = (rx_byte_i == ~sum_q) ? KIND_OK : KIND_BADSUM;
          res_o.packet_id   = id_q;
          res_o.error_flags = flags_q;
          res_o.last        = 1'b1;
        end
        default: begin
          phase_d = (rx_byte_i == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
        end
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      id_q    <= 8'd0;
      flags_q <= 7'd0;
      left_q  <= 8'd0;
      sum_q   <= 8'd0;
    end else begin
      phase_q <= phase_d;
      id_q    <= id_d;
      flags_q <= flags_d;
      left_q  <= left_d;
      sum_q   <= sum_d;
    end
  end

  // A result is only ever produced by an accepted byte.
  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> accept)
    else $error("result pushed without an accepted byte");

  // Status results close a packet and parameter bytes never do.
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (res_o.last == (res_o.kind != KIND_PARAM)))
    else $error("last flag does not match result kind");

  // The parameter phase is entered only with bytes still to come.
  a_param_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PARAM) |-> (left_q != 8'd0))
    else $error("parameter phase with no bytes left");

endmodule

`default_nettype wire

// ----- design/sbsp_queue.sv -----
`default_nettype none

module sbsp_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  sbsp_pkg::sbsp_res_t  res_i,
  output logic                 space_o,
  input  wire                  pop_i,
  output sbsp_pkg::sbsp_qout_t head_o
);
  import sbsp_pkg::*;

  sbsp_res_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]     count_q, count_d;

  assign space_o      = (count_q != QueueCntW'(QueueDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.res   = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

  // Never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue popped while empty");

  // Never push a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> space_o)
    else $error("queue pushed while full");

endmodule

`default_nettype wire

// ----- design/sbsp_back.sv -----
`default_nettype none

module sbsp_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  sbsp_pkg::sbsp_qout_t head_i,
  output logic                 pop_o,
  sbsp_out_if.source           res_o
);
  import sbsp_pkg::*;

  logic      valid_q, valid_d;
  sbsp_res_t res_q;

  // Load the output register from a valid queue head whenever it is empty or being taken.
  assign pop_o   = head_i.valid && (!valid_q || res_o.ready);
  assign valid_d = pop_o ? 1'b1 : (res_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= head_i.res;
    end
  end

  // Drive the output channel from the register.
  assign res_o.valid       = valid_q;
  assign res_o.kind        = res_q.kind;
  assign res_o.data        = res_q.data;
  assign res_o.packet_id   = res_q.packet_id;
  assign res_o.error_flags = res_q.error_flags;
  assign res_o.last        = res_q.last;

endmodule

`default_nettype wire

// ----- design/servo_bus_status_packet_parser.sv -----
// Path: a byte accepted at a clock edge writes its result into the queue at
// that same edge; the result then moves into the output register, from which
// the receiver takes it.
// Throughput: one byte per cycle while the queue has space; the two-entry
// queue and the output register let input and output stall independently.
// Reset (rst_ni, asynchronous, active low) returns the parser to header hunting
// and empties the queue and the output register.
`default_nettype none

module servo_bus_status_packet_parser (
  input  wire         clk_i,
  input  wire         rst_ni,
  sbsp_in_if.sink     rx_i,
  sbsp_out_if.source  res_o
);
  import sbsp_pkg::*;

  logic       space;
  logic       push;
  logic       pop;
  sbsp_res_t  front_res;
  sbsp_qout_t head;

  // Byte parser and classifier.
  sbsp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (rx_i.valid),
    .rx_byte_i (rx_i.rx_byte),
    .space_i   (space),
    .ready_o   (rx_i.ready),
    .push_o    (push),
    .res_o     (front_res)
  );

  // Result queue.
  sbsp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (front_res),
    .space_o (space),
    .pop_i   (pop),
    .head_o  (head)
  );

  // Output register stage.
  sbsp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire

// ----- sim/servo_bus_status_packet_parser_test.sv -----
`timescale 1ns / 1ps

module servo_bus_status_packet_parser_test;
  import sbsp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned TAIL_CYCLES = 8;

  logic clk_i;
  logic rst_ni;

  sbsp_in_if  rx_if ();
  sbsp_out_if res_if ();

  servo_bus_status_packet_parser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if.sink),
    .res_o  (res_if.source)
  );

  // Free-running clock, 2 ns period.
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Parser model state, kept in step with every accepted byte.
  phase_e     ph = PH_HUNT1;
  logic [7:0] cur_id = '0;
  logic [7:0] cur_err = '0;
  logic [7:0] params_due = '0;
  logic [7:0] cur_sum = '0;

  // Results the parser owes us, oldest first.
  sbsp_res_t parse_results_due[$];

  int unsigned item_count = 0;
  int unsigned noise_bytes = 0;
  int unsigned results_seen = 0;
  int unsigned status_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  bit   src_idle_on = 1'b1;
  logic sink_idle_on;
  logic hold_on;
  int unsigned sink_stall_left = 0;
  event hold_start;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want_v);
    $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want_v);
    error_count++;
  endtask

  function automatic void queue_result(kind_e k, logic [7:0] d, logic [7:0] id,
                                       logic [6:0] flags, logic lst);
    sbsp_res_t r;
    r.kind        = k;
    r.data        = d;
    r.packet_id   = id;
    r.error_flags = flags;
    r.last        = lst;
    parse_results_due = {parse_results_due, r};
  endfunction

  // Advance the parser model by one received byte.
  function automatic void parse_byte(input logic [7:0] b);
    case (ph)
      PH_HUNT2: begin
        if (b == HDR_BYTE) begin
          ph = PH_ID;
        end else begin
          ph = PH_HUNT1;
          queue_result(KIND_BADHDR, 8'h00, 8'h00, 7'h00, 1'b1);
        end
      end
      PH_ID: begin
        cur_id  = b;
        cur_sum = b;
        cur_err = 8'h00;
        ph      = PH_LEN;
      end
      PH_LEN: begin
        cur_sum = cur_sum + b;
        if (b < MIN_LEN) begin
          ph = PH_HUNT1;
          queue_result(KIND_BADLEN, 8'h00, cur_id, 7'h00, 1'b1);
        end else begin
          params_due = b - MIN_LEN;
          ph         = PH_ERR;
        end
      end
      PH_ERR: begin
        cur_err = b;
        cur_sum = cur_sum + b;
        if (params_due == 8'h00) begin
          ph = PH_CSUM;
        end else begin
          ph = PH_PARAM;
        end
      end
      PH_PARAM: begin
        cur_sum    = cur_sum + b;
        params_due = params_due - 8'd1;
        if (params_due == 8'h00) begin
          ph = PH_CSUM;
        end
        queue_result(KIND_PARAM, b, cur_id, cur_err[6:0], 1'b0);
      end
      PH_CSUM: begin
        ph = PH_HUNT1;
        if (b == ~cur_sum) begin
          queue_result(KIND_OK, 8'h00, cur_id, cur_err[6:0], 1'b1);
        end else begin
          queue_result(KIND_BADSUM, 8'h00, cur_id, cur_err[6:0], 1'b1);
        end
      end
      default: begin
        if (b == HDR_BYTE) begin
          ph = PH_HUNT2;
        end else begin
          ph = PH_HUNT1;
        end
      end
    endcase
  endfunction

  // Offer one byte, with an occasional idle burst first, and wait for the request to be taken.
  task automatic send_byte(input logic [7:0] b);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    if (ph == PH_HUNT1 && b != HDR_BYTE) begin
      noise_bytes++;
    end else begin
      item_count++;
    end
    parse_byte(b);
  endtask

  // Send a whole status packet with random parameters; a short length stops after the length.
  task automatic send_packet(input logic [7:0] id, input logic [7:0] len,
                             input logic [7:0] err, input bit good_sum);
    logic [7:0] sum;
    logic [7:0] p;
    logic [7:0] csum;
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(id);
    send_byte(len);
    sum = id + len;
    if (len < MIN_LEN) begin
      return;
    end
    send_byte(err);
    sum = sum + err;
    repeat (int'(len - MIN_LEN)) begin
      p = 8'($urandom_range(0, 255));
      send_byte(p);
      sum = sum + p;
    end
    csum = ~sum;
    if (!good_sum) begin
      csum = csum ^ 8'($urandom_range(1, 255));
    end
    send_byte(csum);
  endtask

  // Stop offering and wait until every owed result has come out.
  task automatic wait_for_results();
    rx_if.valid <= 1'b0;
    do @(posedge clk_i); while (parse_results_due.size() != 0);
  endtask

  // Noise, a broken header, short lengths, an empty packet and a bad checksum.
  task automatic test_directed();
    send_byte(8'h00);
    send_byte(HDR_BYTE);
    send_byte(8'h7F);
    send_packet(8'hFF, 8'h00, 8'h00, 1'b1);
    send_packet(8'h00, MIN_LEN, 8'hFF, 1'b1);
    send_packet(8'h12, 8'h03, 8'h80, 1'b0);
    send_packet(8'h5A, 8'h01, 8'h00, 1'b1);
  endtask

  // Mostly well-formed packets with random content, mixed with broken sequences.
  task automatic test_random_packets(input int unsigned target);
    int unsigned start;
    int unsigned pick;
    logic [7:0]  len;
    start = item_count;
    while (item_count - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        if ($urandom_range(0, 29) == 0) begin
          len = 8'($urandom_range(13, 255));
        end else begin
          len = 8'($urandom_range(2, 12));
        end
        send_packet(8'($urandom_range(0, 255)), len, 8'($urandom_range(0, 255)),
                    pick >= 8);
      end else if (pick < 80) begin
        send_packet(8'($urandom_range(0, 255)), 8'($urandom_range(0, 1)), 8'h00, 1'b1);
      end else if (pick < 88) begin
        send_byte(HDR_BYTE);
        send_byte(8'($urandom_range(0, 254)));
      end else if (pick < 94) begin
        // Packet cut short; the following bytes are taken as its body.
        send_byte(HDR_BYTE);
        send_byte(HDR_BYTE);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(2, 8)));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 254)));
      end
    end
  endtask

  // Hold the output off while a long packet streams in, so the input stalls.
  task automatic test_full_queue();
    -> hold_start;
    send_packet(8'($urandom_range(0, 255)), 8'd42, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  // The sender waits for every owed result before carrying on.
  task automatic test_drain_pause();
    repeat (3) send_packet(8'($urandom_range(0, 255)), 8'($urandom_range(2, 6)),
                           8'($urandom_range(0, 255)), 1'b1);
    wait_for_results();
    repeat (3) send_packet(8'($urandom_range(0, 255)), 8'($urandom_range(2, 6)),
                           8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Back-to-back traffic on both sides.
  task automatic test_no_idle();
    src_idle_on = 1'b0;
    sink_idle_on <= 1'b0;
    test_random_packets(200);
  endtask

  // Receiver: random stall bursts, plus the long hold when asked.
  always @(posedge clk_i) begin
    if (hold_on) begin
      res_if.ready <= 1'b0;
    end else if (sink_stall_left != 0) begin
      res_if.ready    <= 1'b0;
      sink_stall_left <= sink_stall_left - 1;
    end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
      res_if.ready    <= 1'b0;
      sink_stall_left <= $urandom_range(0, 2);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Long hold on the output, counted in cycles.
  initial begin
    hold_on <= 1'b0;
    forever begin
      @(hold_start);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_on <= 1'b0;
    end
  end

  // Compare every result taken from the block with the oldest one owed.
  always @(posedge clk_i) begin
    sbsp_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      if (res_if.last) begin
        status_seen++;
      end
      if (parse_results_due.size() == 0) begin
        report_mismatch("unexpected result kind", res_if.kind, 0);
      end else begin
        want = parse_results_due.pop_front();
        if (res_if.kind !== want.kind) begin
          report_mismatch("kind", res_if.kind, want.kind);
        end
        if (res_if.data !== want.data) begin
          report_mismatch("data", res_if.data, want.data);
        end
        if (res_if.packet_id !== want.packet_id) begin
          report_mismatch("packet_id", res_if.packet_id, want.packet_id);
        end
        if (res_if.error_flags !== want.error_flags) begin
          report_mismatch("error_flags", res_if.error_flags, want.error_flags);
        end
        if (res_if.last !== want.last) begin
          report_mismatch("last", res_if.last, want.last);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Watchdog expired with %0d results still owed.", parse_results_due.size());
      $display("servo_bus_status_packet_parser verification failed");
      $finish;
    end
  end

  initial begin
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    sink_idle_on  <= 1'b1;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_packets(950);
    test_full_queue();
    test_drain_pause();
    test_no_idle();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d packet bytes and %0d noise bytes, with random gaps and stalls.",
             item_count, noise_bytes);
    $display("Checked %0d results, %0d of them end-of-packet status.",
             results_seen, status_seen);
    if (error_count == 0) begin
      $display("servo_bus_status_packet_parser verification clean");
    end else begin
      $display("servo_bus_status_packet_parser verification failed");
    end
    $finish;
  end

endmodule
